// ===== design/cubic_bezier_point_generator_top_assert.svh =====
// Assertion macros shared by the checker of the cubic Bezier point generator.
`ifndef CUBIC_BEZIER_POINT_GENERATOR_TOP_ASSERT_SVH
`define CUBIC_BEZIER_POINT_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define CBEZ_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define CBEZ_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/cbez_pkg.sv =====
// Shared constants and types of the cubic Bezier point generator.
package cbez_pkg;

  // Coordinate format and register width.
  localparam int COORD_W = 16;
  localparam int SEG_W = 6;
  localparam logic [SEG_W-1:0] SEG_RESET = 6'd32;
  localparam int MAX_SEGMENTS_DEF = 63;

  // Curve shape.
  localparam int NUM_CTRL = 4;
  localparam int NUM_AXES = 2;

  // Quotient bits resolved per divider stage, and the resulting stage count.
  localparam int DIV_STEP = 2;
  localparam int DIV_STAGES = COORD_W / DIV_STEP;

  // Curve queue between front and back (a power of two).
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // One queued curve: control points per axis and the interval count.
  typedef struct packed {
    logic [NUM_CTRL-1:0][COORD_W-1:0] ctrl_x;
    logic [NUM_CTRL-1:0][COORD_W-1:0] ctrl_y;
    logic [SEG_W-1:0]                 segs;
  } curve_t;

  // Sideband that travels with every point through the pipeline.
  typedef struct packed {
    logic vld;
    logic last;
  } pt_tag_t;

endpackage

// ===== design/cbez_front.sv =====
// Front end: accepts curves, normalizes the interval count and queues them.
module cbez_front import cbez_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  curve_t curve_i,
  output logic   q_valid_o,
  output curve_t q_item_o,
  input  logic   q_pop_i
);

  curve_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [SEG_W-1:0]  segs_fix;
  curve_t            entry;
  logic              push;

  // Zero intervals become one, and counts above the maximum saturate.
  always_comb begin
    priority if (curve_i.segs == '0) begin
      segs_fix = SEG_W'(1);
    end else if (curve_i.segs > SEG_W'(MAX_SEGMENTS)) begin
      segs_fix = SEG_W'(MAX_SEGMENTS);
    end else begin
      segs_fix = curve_i.segs;
    end
    entry      = curve_i;
    entry.segs = segs_fix;
  end

  assign in_ready  = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign q_valid_o = (cnt_r != '0);
  assign q_item_o  = mem_r[rd_ptr_r];

  // Occupancy follows the push and pop of each cycle.
  always_comb begin
    unique case ({push, q_pop_i})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop_i) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Queue storage is written on every input transfer.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// ===== design/cbez_back.sv =====
// Back end: steps t over each queued curve and forms the Bernstein-weighted sums.
module cbez_back import cbez_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  localparam int DW = $clog2(MAX_SEGMENTS**3 + 1),
  localparam int NW = DW + COORD_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv_i,
  input  logic                           q_valid_i,
  input  curve_t                         q_item_i,
  output logic                           q_pop_o,
  output logic [NUM_AXES-1:0][NW-1:0]    num_o,
  output logic [DW-1:0]                  den_o,
  output pt_tag_t                        tag_o
);

  localparam int KW  = $clog2(MAX_SEGMENTS + 1);
  localparam int KW2 = 2 * KW;
  localparam int WW  = $clog2(3 * MAX_SEGMENTS**3 + 1);
  localparam int PW  = WW + COORD_W;

  typedef logic [NUM_AXES-1:0][NUM_CTRL-1:0][COORD_W-1:0] ctrl_set_t;

  // Step sequencer.
  logic [KW-1:0]  k_r, k_nxt, n_h;
  logic           last_h, issue;
  pt_tag_t        issue_tag;

  // Stage 1: squares and cross terms of k and j = n - k.
  pt_tag_t        tag1_r;
  logic [KW-1:0]  k1_r, j1_r, n1_r;
  logic [KW2-1:0] kk1_r, jj1_r, kj1_r, nn1_r;
  ctrl_set_t      ctrl1_r;

  // Stage 2: the four cubic weights and the denominator n^3.
  pt_tag_t                    tag2_r;
  logic [NUM_CTRL-1:0][WW-1:0] w2_r, w_nxt;
  logic [DW-1:0]              den2_r;
  ctrl_set_t                  ctrl2_r;
  logic [WW-1:0]              kjj, kkj;

  // Stage 3: weight times coordinate.
  pt_tag_t                                  tag3_r;
  logic [NUM_AXES-1:0][NUM_CTRL-1:0][PW-1:0] prod3_r;
  logic [DW-1:0]                            den3_r;

  // Stage 4: rounded numerator.
  pt_tag_t                      tag4_r;
  logic [NUM_AXES-1:0][NW-1:0]  num4_r, num_nxt;
  logic [DW-1:0]                den4_r;

  // One t step is issued per advancing cycle while a curve is queued; the last step frees the queue head.
  assign n_h       = q_item_i.segs[KW-1:0];
  assign last_h    = (k_r == n_h);
  assign issue     = q_valid_i && adv_i;
  assign q_pop_o   = issue && last_h;
  assign issue_tag = '{vld: issue, last: last_h};
  assign k_nxt     = last_h ? '0 : k_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (issue) begin
      k_r <= k_nxt;
    end
  end

  // Valid and last flags move through the stages together with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.vld <= 1'b0;
      tag2_r.vld <= 1'b0;
      tag3_r.vld <= 1'b0;
      tag4_r.vld <= 1'b0;
    end else if (adv_i) begin
      tag1_r <= issue_tag;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
    end
  end

  // Weights from the products of stage 1; the factor three is a shift and add.
  always_comb begin
    kjj      = WW'(kj1_r) * WW'(j1_r);
    kkj      = WW'(kj1_r) * WW'(k1_r);
    w_nxt[0] = WW'(jj1_r) * WW'(j1_r);
    w_nxt[1] = kjj + (kjj << 1);
    w_nxt[2] = kkj + (kkj << 1);
    w_nxt[3] = WW'(kk1_r) * WW'(k1_r);
  end

  // Sum of the four weighted coordinates plus half the denominator.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      num_nxt[a] = NW'(den3_r >> 1);
      for (int i = 0; i < NUM_CTRL; i++) begin
        num_nxt[a] = num_nxt[a] + NW'(prod3_r[a][i]);
      end
    end
  end

  // Data path registers, loaded whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (adv_i) begin
      k1_r    <= k_r;
      j1_r    <= n_h - k_r;
      n1_r    <= n_h;
      kk1_r   <= KW2'(k_r) * KW2'(k_r);
      jj1_r   <= KW2'(n_h - k_r) * KW2'(n_h - k_r);
      kj1_r   <= KW2'(k_r) * KW2'(n_h - k_r);
      nn1_r   <= KW2'(n_h) * KW2'(n_h);
      ctrl1_r <= {q_item_i.ctrl_y, q_item_i.ctrl_x};

      w2_r    <= w_nxt;
      den2_r  <= DW'(DW'(nn1_r) * DW'(n1_r));
      ctrl2_r <= ctrl1_r;

      for (int a = 0; a < NUM_AXES; a++) begin
        for (int i = 0; i < NUM_CTRL; i++) begin
          prod3_r[a][i] <= PW'(w2_r[i]) * PW'(ctrl2_r[a][i]);
        end
      end
      den3_r <= den2_r;

      num4_r <= num_nxt;
      den4_r <= den3_r;
    end
  end

  assign num_o = num4_r;
  assign den_o = den4_r;
  assign tag_o = tag4_r;

endmodule

// ===== design/cbez_div.sv =====
// Pipelined restoring divider for both axes; its last stage is the output register.
module cbez_div import cbez_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  localparam int DW = $clog2(MAX_SEGMENTS**3 + 1),
  localparam int NW = DW + COORD_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv_i,
  input  logic [NUM_AXES-1:0][NW-1:0] num_i,
  input  logic [DW-1:0]               den_i,
  input  pt_tag_t                     tag_i,
  output logic                        out_valid,
  output logic [COORD_W-1:0]          out_point_x,
  output logic [COORD_W-1:0]          out_point_y,
  output logic                        out_last_point
);

  // Per stage: partial remainder, and a word whose upper part holds the dividend
  // bits still to come while the quotient bits fill in from below.
  pt_tag_t [DIV_STAGES-1:0]                         tag_r;
  logic [DIV_STAGES-1:0][NUM_AXES-1:0][COORD_W-1:0] lq_r, lq_nxt;
  logic [DIV_STAGES-1:0][NUM_AXES-1:0][DW-1:0]      rem_nxt;
  logic [DIV_STAGES-2:0][NUM_AXES-1:0][DW-1:0]      rem_r;
  logic [DIV_STAGES-2:0][DW-1:0]                    den_r;

  // Each stage resolves DIV_STEP quotient bits by compare and subtract.
  always_comb begin
    logic [DW-1:0]      r;
    logic [COORD_W-1:0] lq;
    logic [DW-1:0]      d;
    logic [DW:0]        trial;
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (s == 0) begin
          d  = den_i;
          r  = num_i[a][NW-1:COORD_W];
          lq = num_i[a][COORD_W-1:0];
        end else begin
          d  = den_r[s-1];
          r  = rem_r[s-1][a];
          lq = lq_r[s-1][a];
        end
        for (int b = 0; b < DIV_STEP; b++) begin
          trial = {r, lq[COORD_W-1]};
          lq    = {lq[COORD_W-2:0], 1'b0};
          if (trial >= {1'b0, d}) begin
            trial = trial - {1'b0, d};
            lq[0] = 1'b1;
          end
          r = trial[DW-1:0];
        end
        rem_nxt[s][a] = r;
        lq_nxt[s][a]  = lq;
      end
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        tag_r[s].vld <= 1'b0;
      end
    end else if (adv_i) begin
      tag_r[0] <= tag_i;
      for (int s = 1; s < DIV_STAGES; s++) begin
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  // Stage data.
  always_ff @(posedge clk) begin
    if (adv_i) begin
      lq_r <= lq_nxt;
      for (int s = 0; s < DIV_STAGES - 1; s++) begin
        rem_r[s] <= rem_nxt[s];
        den_r[s] <= (s == 0) ? den_i : den_r[s-1];
      end
    end
  end

  // The quotient never exceeds the coordinate range, so no clamp is left to do.
  assign out_valid      = tag_r[DIV_STAGES-1].vld;
  assign out_last_point = tag_r[DIV_STAGES-1].last;
  assign out_point_x    = lq_r[DIV_STAGES-1][0];
  assign out_point_y    = lq_r[DIV_STAGES-1][1];

endmodule

// ===== design/cubic_bezier_point_generator_top.sv =====
// Cubic Bezier point generator. Each accepted curve (four control points, unsigned
// Q12.4) yields N+1 points at t = k/N, k = 0..N, with N taken from the segments
// register when the curve is accepted (0 counts as 1); the point at t = 1 carries
// out_last_point. Points are exact Bernstein sums over N^3, rounded to nearest with
// halves up. Throughput is one point per cycle while the output is not stalled;
// the step sequencer issues one t value per advancing cycle into a fully pipelined
// weight, multiply and divide path of four arithmetic stages and eight two-bit
// divider stages, the last being the output register. A two-curve queue in front
// lets new curves be taken while points are still being produced or held by a
// stalled output.
module cubic_bezier_point_generator_top import cbez_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [SEG_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] in_ctrl0_x,
  input  logic [COORD_W-1:0] in_ctrl0_y,
  input  logic [COORD_W-1:0] in_ctrl1_x,
  input  logic [COORD_W-1:0] in_ctrl1_y,
  input  logic [COORD_W-1:0] in_ctrl2_x,
  input  logic [COORD_W-1:0] in_ctrl2_y,
  input  logic [COORD_W-1:0] in_ctrl3_x,
  input  logic [COORD_W-1:0] in_ctrl3_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] out_point_x,
  output logic [COORD_W-1:0] out_point_y,
  output logic               out_last_point
);

  localparam int DW = $clog2(MAX_SEGMENTS**3 + 1);
  localparam int NW = DW + COORD_W;

  logic [SEG_W-1:0]            segments_r;
  curve_t                      curve_in, q_item;
  logic                        q_valid, q_pop, adv;
  logic [NUM_AXES-1:0][NW-1:0] num;
  logic [DW-1:0]               den;
  pt_tag_t                     tag;

  // Segments register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segments_r <= SEG_RESET;
    end else if (cfg_wr_en) begin
      segments_r <= cfg_wr_data;
    end
  end

  // Gather the input transfer into one curve record.
  assign curve_in.ctrl_x = {in_ctrl3_x, in_ctrl2_x, in_ctrl1_x, in_ctrl0_x};
  assign curve_in.ctrl_y = {in_ctrl3_y, in_ctrl2_y, in_ctrl1_y, in_ctrl0_y};
  assign curve_in.segs   = segments_r;

  // The whole point pipeline moves unless a finished point is stuck at the output.
  assign adv = !out_valid || out_ready;

  cbez_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .curve_i   (curve_in),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  cbez_back #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv_i     (adv),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .num_o     (num),
    .den_o     (den),
    .tag_o     (tag)
  );

  cbez_div #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_div (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv_i          (adv),
    .num_i          (num),
    .den_i          (den),
    .tag_i          (tag),
    .out_valid      (out_valid),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_point (out_last_point)
  );

endmodule

// ===== design/cbez_checker.sv =====
// Port-level checker for the cubic Bezier point generator, bound to the top level.
`include "cubic_bezier_point_generator_top_assert.svh"

module cbez_checker import cbez_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COORD_W-1:0] out_point_x,
  input logic [COORD_W-1:0] out_point_y,
  input logic               out_last_point
);

  localparam int PTS_W = SEG_W + 1;
  localparam int PEND_W = 8;

  logic [PEND_W-1:0] pending_r;
  logic [PTS_W-1:0]  pts_r;
  logic              in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Curves accepted whose final point has not yet gone out, and points of the
  // current curve already delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      pts_r     <= '0;
    end else begin
      pending_r <= pending_r + PEND_W'(in_xfer) - PEND_W'(out_xfer && out_last_point);
      if (out_xfer) begin
        pts_r <= out_last_point ? '0 : pts_r + 1'b1;
      end
    end
  end

  `CBEZ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_point_x) && $stable(out_point_y) && $stable(out_last_point), "stalled point changed")
  `CBEZ_ASSERT_IMP(a_out_owed, out_valid, pending_r != '0, "point shown with no curve outstanding")
  `CBEZ_ASSERT_IMP(a_first_not_last, out_valid && pts_r == '0, !out_last_point, "curve ended on its first point")
  `CBEZ_ASSERT_IMP(a_max_points, out_valid && pts_r == PTS_W'(MAX_SEGMENTS), out_last_point, "curve ran past the maximum point count")

endmodule

bind cubic_bezier_point_generator_top cbez_checker #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_chk (.*);

// ===== test/tb_cubic_bezier_point_generator_top.sv =====
// Self-checking testbench for the cubic Bezier point generator top level.
module tb_cubic_bezier_point_generator_top;
  import cbez_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 30;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_CURVES = 30;
  localparam logic [COORD_W-1:0] COORD_TOP = '1;

  // One curve segment as offered on the input channel.
  typedef struct packed {
    logic [NUM_CTRL-1:0][COORD_W-1:0] x;
    logic [NUM_CTRL-1:0][COORD_W-1:0] y;
  } bezier_seg_t;

  // One sample point as seen on the result channel.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } curve_point_t;

  // Keeps its own copy of the segments register and the points still owed.
  class point_scoreboard;
    logic [SEG_W-1:0] segments;
    curve_point_t     owed_points[$];
    int               errors;

    function new();
      segments = SEG_RESET;
      errors = 0;
    endfunction

    function void set_segments(logic [SEG_W-1:0] value);
      segments = value;
    endfunction

    function int pending();
      return owed_points.size();
    endfunction

    // Exact Bernstein sum over n^3, rounded half up and clamped.
    function logic [COORD_W-1:0] bernstein_axis(logic [NUM_CTRL-1:0][COORD_W-1:0] p,
                                                longint unsigned k, longint unsigned n);
      longint unsigned j;
      longint unsigned den;
      longint unsigned num;
      longint unsigned q;
      j = n - k;
      den = n * n * n;
      num = j * j * j * p[0] + 64'd3 * k * j * j * p[1]
          + 64'd3 * k * k * j * p[2] + k * k * k * p[3];
      q = (num + den / 2) / den;
      if (q > COORD_TOP) q = COORD_TOP;
      return q[COORD_W-1:0];
    endfunction

    // An accepted curve owes n+1 points, t = k/n for k = 0..n.
    function void note_curve(bezier_seg_t c);
      longint unsigned n;
      curve_point_t pt;
      n = 64'(segments);
      if (n == 0) n = 1;
      if (n > MAX_SEGMENTS_DEF) n = MAX_SEGMENTS_DEF;
      for (longint unsigned k = 0; k <= n; k++) begin
        pt.x = bernstein_axis(c.x, k, n);
        pt.y = bernstein_axis(c.y, k, n);
        pt.last = (k == n);
        owed_points = {owed_points, pt};
      end
    endfunction

    // Compare one transferred point with the oldest point owed.
    function void check_point(curve_point_t got);
      curve_point_t exp_pt;
      if (owed_points.size() == 0) begin
        $error("unexpected point x=%0h y=%0h last=%0b", got.x, got.y, got.last);
        errors++;
        return;
      end
      exp_pt = owed_points.pop_front();
      if (got.x !== exp_pt.x) begin
        $error("point_x: expected %0h, actual %0h", exp_pt.x, got.x);
        errors++;
      end
      if (got.y !== exp_pt.y) begin
        $error("point_y: expected %0h, actual %0h", exp_pt.y, got.y);
        errors++;
      end
      if (got.last !== exp_pt.last) begin
        $error("last_point: expected %0b, actual %0b", exp_pt.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [SEG_W-1:0]   cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [COORD_W-1:0] in_x [NUM_CTRL] = '{default: '0};
  logic [COORD_W-1:0] in_y [NUM_CTRL] = '{default: '0};
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [COORD_W-1:0] out_point_x;
  logic [COORD_W-1:0] out_point_y;
  logic               out_last_point;

  point_scoreboard points_sb;
  int send_idle_pct = 36;
  int recv_idle_pct = 51;
  int holds_requested = 0;
  int holds_served = 0;
  int quiet_cycles = 0;

  cubic_bezier_point_generator_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_ctrl0_x(in_x[0]),
    .in_ctrl0_y(in_y[0]),
    .in_ctrl1_x(in_x[1]),
    .in_ctrl1_y(in_y[1]),
    .in_ctrl2_x(in_x[2]),
    .in_ctrl2_y(in_y[2]),
    .in_ctrl3_x(in_x[3]),
    .in_ctrl3_y(in_y[3]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_point_x(out_point_x),
    .out_point_y(out_point_y),
    .out_last_point(out_last_point)
  );

  // Free-running clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random back-pressure, plus long hold-offs when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_requested != holds_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every result transfer against the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      points_sb.check_point('{out_point_x, out_point_y, out_last_point});
  end

  // Watchdog: end the run if no transfer happens for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [COORD_W-1:0] random_coord();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return COORD_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic bezier_seg_t random_seg();
    bezier_seg_t c;
    for (int i = 0; i < NUM_CTRL; i++) begin
      c.x[i] = random_coord();
      c.y[i] = random_coord();
    end
    return c;
  endfunction

  function automatic bezier_seg_t seg_from(logic [COORD_W-1:0] x0, y0, x1, y1,
                                           x2, y2, x3, y3);
    bezier_seg_t c;
    c.x = {x3, x2, x1, x0};
    c.y = {y3, y2, y1, y0};
    return c;
  endfunction

  // Offer one curve after a random idle gap and wait for its transfer.
  task automatic offer_curve(bezier_seg_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < NUM_CTRL; i++) begin
      in_x[i] <= c.x[i];
      in_y[i] <= c.y[i];
    end
    do @(posedge clk); while (!in_ready);
    points_sb.note_curve(c);
  endtask

  // Stop offering and wait until every owed point has been transferred.
  task automatic settle();
    in_valid <= 1'b0;
    while (points_sb.pending() != 0) @(posedge clk);
  endtask

  // Register write; only issued while the block is idle.
  task automatic write_segments(logic [SEG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    points_sb.set_segments(value);
  endtask

  initial begin
    logic [SEG_W-1:0] seg_count;
    points_sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed curves at the reset value of the segments register.
    offer_curve(seg_from('0, '0, '0, '0, '0, '0, '0, '0));
    offer_curve(seg_from('1, '1, '1, '1, '1, '1, '1, '1));
    offer_curve(seg_from('0, '1, '1, '0, '0, '1, '1, '0));
    offer_curve(seg_from(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
                         16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
    offer_curve(seg_from('0, '1, '1, '0, '1, '0, '0, '1));
    offer_curve(random_seg());

    // Zero segments behaves as one interval.
    settle();
    write_segments(6'd0);
    offer_curve(random_seg());
    offer_curve(seg_from('1, '0, '0, '1, '1, '0, '0, '1));

    settle();
    write_segments(6'd1);
    offer_curve(random_seg());
    offer_curve(random_seg());

    // Two intervals: the midpoint lands exactly on a half and rounds up.
    settle();
    write_segments(6'd2);
    offer_curve(seg_from(16'd4, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd4));
    offer_curve(random_seg());

    // Largest interval count.
    settle();
    write_segments(6'd63);
    offer_curve(seg_from('1, '1, '1, '1, '1, '1, '1, '1));
    offer_curve(seg_from('0, '1, '0, '0, '0, '0, '1, '0));

    // Random phases; mostly short curves, a few long ones.
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      if (p == 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 36;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 4) seg_count = 6'd63;
      else if (p == 7) seg_count = SEG_W'($urandom_range(9, 62));
      else seg_count = SEG_W'($urandom_range(0, 8));
      write_segments(seg_count);
      // Long output stall while the sender keeps offering curves.
      if (p == 6) holds_requested++;
      repeat (PHASE_CURVES) offer_curve(random_seg());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (points_sb.errors == 0 && points_sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
